// ----- sv/yuv_to_rgb_rotate_writer_assert.svh -----
// Assertion macros for the converter RTL.
`ifndef YUV_TO_RGB_ROTATE_WRITER_ASSERT_SVH
`define YUV_TO_RGB_ROTATE_WRITER_ASSERT_SVH

`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- sv/yrrw_pkg.sv -----
// Package: widths, register codes, coefficients and channel clamp for the converter.
package yrrw_pkg;

  localparam int MAX_DIM_DEFAULT = 4096;
  localparam int CFG_W           = 13;
  localparam int CFG_IDX_W       = 3;
  localparam int POS_W           = 12;
  localparam int SAMPLE_W        = 8;
  localparam int DEST_INDEX_W    = 25;
  localparam int COL_W           = 22;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROTATION_MODE = 3'd0,
    REG_DEST_WIDTH    = 3'd1,
    REG_DEST_HEIGHT   = 3'd2,
    REG_DEST_STRIDE   = 3'd3,
    REG_CROP_WIDTH    = 3'd4,
    REG_CROP_HEIGHT   = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ROT_NONE = 2'd0,
    ROT_90   = 2'd1,
    ROT_180  = 2'd2,
    ROT_270  = 2'd3
  } rot_mode_t;

  localparam logic [CFG_W-1:0] DEST_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] DEST_HEIGHT_RST = 13'd480;
  localparam logic [CFG_W-1:0] DEST_STRIDE_RST = 13'd640;
  localparam logic [CFG_W-1:0] CROP_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] CROP_HEIGHT_RST = 13'd480;

  localparam logic [SAMPLE_W-1:0] LUMA_OFFSET   = 8'd16;
  localparam logic signed [8:0]   CHROMA_OFFSET = 9'sd128;

  localparam logic signed [COL_W-1:0] COEF_Y  = 22'sd1192;
  localparam logic signed [COL_W-1:0] COEF_RV = 22'sd1634;
  localparam logic signed [COL_W-1:0] COEF_GV = 22'sd833;
  localparam logic signed [COL_W-1:0] COEF_GU = 22'sd400;
  localparam logic signed [COL_W-1:0] COEF_BU = 22'sd2066;
  localparam logic signed [COL_W-1:0] CHAN_MAX = 22'sd262143;
  localparam int CHAN_SHIFT = 10;

  // Clamp to 0..262143 and keep bits 17..10.
  function automatic logic [SAMPLE_W-1:0] clamp_channel(input logic signed [COL_W-1:0] v);
    logic [COL_W-1:0] sh;
    sh = COL_W'(v) >> CHAN_SHIFT;
    if (v < 0) begin
      return '0;
    end else if (v > CHAN_MAX) begin
      return '1;
    end else begin
      return sh[SAMPLE_W-1:0];
    end
  endfunction

endpackage

// ----- sv/yuv_to_rgb_rotate_writer.sv -----
// Top level: pipelined BT.601 YUV to RGB converter with rotated destination addressing.

// One pixel per clock, sustained. A pixel transfer happens at a clock edge with start high
// and busy low; its result appears on the output ports with done high for one cycle and must
// be taken then. It passes four register stages: input capture, coefficient products and
// placement terms, channel sums and the single row-times-stride multiplier, then clamping
// and the final index add. busy is high only while rst is asserted. Configuration writes
// are taken any cycle but should be made with the pipeline empty; a pixel started in the
// cycle after a write already sees it. dest_index is 0 and in_range is 0 for pixels outside
// the drawn area.
`include "yuv_to_rgb_rotate_writer_assert.svh"

module yuv_to_rgb_rotate_writer
  import yrrw_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [SAMPLE_W-1:0]     luma,
  input  logic [SAMPLE_W-1:0]     chroma_u,
  input  logic [SAMPLE_W-1:0]     chroma_v,
  input  logic [POS_W-1:0]        src_col,
  input  logic [POS_W-1:0]        src_row,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  output logic                    done,
  output logic [DEST_INDEX_W-1:0] dest_index,
  output logic [SAMPLE_W-1:0]     red,
  output logic [SAMPLE_W-1:0]     green,
  output logic [SAMPLE_W-1:0]     blue,
  output logic                    in_range
);

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int SAT_W  = (DIM_W > CFG_W) ? DIM_W : CFG_W;
  localparam int CMP_W  = (DIM_W > POS_W) ? DIM_W : POS_W;
  localparam int PROD_W = 2 * DIM_W + 1;
  localparam int SUM_W  = (PROD_W > DEST_INDEX_W) ? PROD_W : DEST_INDEX_W;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [CFG_W-1:0] v);
    logic [SAT_W-1:0] ve;
    ve = SAT_W'(v);
    if (ve > SAT_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end else begin
      return DIM_W'(ve);
    end
  endfunction

  // configuration registers
  rot_mode_t        rotation_mode;
  logic [CFG_W-1:0] dest_width;
  logic [CFG_W-1:0] dest_height;
  logic [CFG_W-1:0] dest_stride;
  logic [CFG_W-1:0] crop_width;
  logic [CFG_W-1:0] crop_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_mode <= ROT_NONE;
      dest_width    <= DEST_WIDTH_RST;
      dest_height   <= DEST_HEIGHT_RST;
      dest_stride   <= DEST_STRIDE_RST;
      crop_width    <= CROP_WIDTH_RST;
      crop_height   <= CROP_HEIGHT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROTATION_MODE: rotation_mode <= rot_mode_t'(cfg_data[1:0]);
        REG_DEST_WIDTH:    dest_width    <= cfg_data;
        REG_DEST_HEIGHT:   dest_height   <= cfg_data;
        REG_DEST_STRIDE:   dest_stride   <= cfg_data;
        REG_CROP_WIDTH:    crop_width    <= cfg_data;
        REG_CROP_HEIGHT:   crop_height   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Drawn-area geometry, refreshed every cycle from the registers.
  logic [DIM_W-1:0] dw_s, dh_s, cw_s, ch_s;
  logic [DIM_W-1:0] w_next, h_next;
  logic             swap;
  rot_mode_t        mode_q;
  logic [DIM_W-1:0] w_q, h_q, ds_q, dx_q, dy_q;

  always_comb begin
    dw_s   = sat_dim(dest_width);
    dh_s   = sat_dim(dest_height);
    cw_s   = sat_dim(crop_width);
    ch_s   = sat_dim(crop_height);
    swap   = (rotation_mode == ROT_90) || (rotation_mode == ROT_270);
    w_next = swap ? ((dh_s < cw_s) ? dh_s : cw_s) : ((dw_s < cw_s) ? dw_s : cw_s);
    h_next = swap ? ((dw_s < ch_s) ? dw_s : ch_s) : ((dh_s < ch_s) ? dh_s : ch_s);
  end

  always_ff @(posedge clk) begin
    mode_q <= rotation_mode;
    w_q    <= w_next;
    h_q    <= h_next;
    ds_q   <= sat_dim(dest_stride);
    // only used in the 90-degree placement, where dh >= w and dw >= h
    dx_q   <= (dh_s - w_next) >> 1;
    dy_q   <= (dw_s - h_next) >> 1;
  end

  assign busy = rst;

  // stage 1: capture, offsets
  logic                    v1;
  logic [SAMPLE_W-1:0]     y1;
  logic signed [8:0]       u1, cv1;
  logic [POS_W-1:0]        x1, r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    y1  <= (luma > LUMA_OFFSET) ? (luma - LUMA_OFFSET) : '0;
    u1  <= $signed({1'b0, chroma_u}) - CHROMA_OFFSET;
    cv1 <= $signed({1'b0, chroma_v}) - CHROMA_OFFSET;
    x1  <= src_col;
    r1  <= src_row;
  end

  // stage 2: coefficient products, range test, multiplicand and addend
  logic                    v2;
  logic signed [COL_W-1:0] py2, prv2, pgv2, pgu2, pbu2;
  logic                    ok2;
  logic [DIM_W-1:0]        m2, a2;
  logic                    ok_next;
  logic [DIM_W-1:0]        m_next, a_next, xd, yd;

  always_comb begin
    ok_next = (CMP_W'(x1) < CMP_W'(w_q)) && (CMP_W'(r1) < CMP_W'(h_q));
    // in range, both coordinates are below a dimension and fit
    xd = DIM_W'(x1);
    yd = DIM_W'(r1);
    unique case (mode_q)
      ROT_NONE: begin
        m_next = yd;
        a_next = xd;
      end
      ROT_90: begin
        m_next = xd + dx_q;
        a_next = dy_q + (h_q - DIM_W'(1) - yd);
      end
      ROT_180: begin
        m_next = h_q - DIM_W'(1) - yd;
        a_next = w_q - DIM_W'(1) - xd;
      end
      ROT_270: begin
        m_next = w_q - DIM_W'(1) - xd;
        a_next = yd;
      end
      default: begin
        m_next = '0;
        a_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    py2  <= $signed(COL_W'(y1)) * COEF_Y;
    prv2 <= COL_W'(cv1) * COEF_RV;
    pgv2 <= COL_W'(cv1) * COEF_GV;
    pgu2 <= COL_W'(u1) * COEF_GU;
    pbu2 <= COL_W'(u1) * COEF_BU;
    ok2  <= ok_next;
    m2   <= m_next;
    a2   <= a_next;
  end

  // stage 3: channel sums, index product
  logic                    v3;
  logic signed [COL_W-1:0] r3, g3, b3;
  logic [SUM_W-1:0]        prod3;
  logic [DIM_W-1:0]        a3;
  logic                    ok3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    r3    <= py2 + prv2;
    g3    <= py2 - pgv2 - pgu2;
    b3    <= py2 + pbu2;
    prod3 <= SUM_W'(m2) * SUM_W'(ds_q);
    a3    <= a2;
    ok3   <= ok2;
  end

  // stage 4: clamp and final index
  logic [SUM_W-1:0] idx_sum;

  assign idx_sum = prod3 + SUM_W'(a3);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v3;
    end
  end

  always_ff @(posedge clk) begin
    red        <= clamp_channel(r3);
    green      <= clamp_channel(g3);
    blue       <= clamp_channel(b3);
    dest_index <= ok3 ? idx_sum[DEST_INDEX_W-1:0] : '0;
    in_range   <= ok3;
  end

  `ASSERT_IMPLIES(a_fixed_latency, clk, rst, !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3), done == $past(start && !busy, 4))
  `ASSERT_NEXT(a_stage3_to_done, clk, rst, v3, done)
  `ASSERT_IMPLIES(a_outside_zero_index, clk, rst, done && !in_range, dest_index == '0)
  `ASSERT_IMPLIES(a_no_accept_in_reset, clk, 1'b0, rst, busy)

endmodule

// ----- sim/yuv_to_rgb_rotate_writer_tb.sv -----
// Self-checking testbench for the YUV to RGB converter with rotated destination placement.
module yuv_to_rgb_rotate_writer_tb
  import yrrw_pkg::*;
();

  localparam int PIPE_LAT    = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_PHASES  = 25;
  localparam int MAX_MSGS    = 100;
  localparam int NUM_DIR     = 32;

  // register indexes past the last register; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct {
    logic [SAMPLE_W-1:0] luma;
    logic [SAMPLE_W-1:0] cu;
    logic [SAMPLE_W-1:0] cv;
    logic [POS_W-1:0]    col;
    logic [POS_W-1:0]    row;
  } pixel_t;

  typedef struct {
    logic [DEST_INDEX_W-1:0] idx;
    logic [SAMPLE_W-1:0]     red;
    logic [SAMPLE_W-1:0]     green;
    logic [SAMPLE_W-1:0]     blue;
    logic                    ok;
  } placed_t;

  typedef enum bit {STEP_PIXEL, STEP_WRITE} step_kind_t;

  typedef struct {
    step_kind_t              kind;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [CFG_W-1:0]        reg_val;
    logic [SAMPLE_W-1:0]     luma;
    logic [SAMPLE_W-1:0]     cu;
    logic [SAMPLE_W-1:0]     cv;
    logic [POS_W-1:0]        col;
    logic [POS_W-1:0]        row;
    bit                      typed;
    logic [DEST_INDEX_W-1:0] w_idx;
    logic [SAMPLE_W-1:0]     w_red;
    logic [SAMPLE_W-1:0]     w_green;
    logic [SAMPLE_W-1:0]     w_blue;
    logic                    w_ok;
  } dir_step_t;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [SAMPLE_W-1:0]     luma;
  logic [SAMPLE_W-1:0]     chroma_u;
  logic [SAMPLE_W-1:0]     chroma_v;
  logic [POS_W-1:0]        src_col;
  logic [POS_W-1:0]        src_row;
  logic                    cfg_write;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_data;
  logic                    done;
  logic [DEST_INDEX_W-1:0] dest_index;
  logic [SAMPLE_W-1:0]     red;
  logic [SAMPLE_W-1:0]     green;
  logic [SAMPLE_W-1:0]     blue;
  logic                    in_range;

  // register mirror
  rot_mode_t        cur_mode;
  logic [CFG_W-1:0] cur_dest_w;
  logic [CFG_W-1:0] cur_dest_h;
  logic [CFG_W-1:0] cur_stride;
  logic [CFG_W-1:0] cur_crop_w;
  logic [CFG_W-1:0] cur_crop_h;

  placed_t pending_pixels[$];
  bit      failed;
  int      msg_count;

  // Pixel rows carry an unused register field; write rows carry unused pixel fields.
  // Starts at the reset settings: mode none, 640x480 destination and crop, stride 640.
  dir_step_t dir_steps [NUM_DIR] = '{
    '{STEP_PIXEL, REG_ROTATION_MODE, 0, 16, 128, 128, 0, 0, 1, 0, 0, 0, 0, 1},
    '{STEP_PIXEL, REG_ROTATION_MODE, 0, 255, 128, 128, 639, 479, 1, 307199, 255, 255, 255, 1},
    '{STEP_PIXEL, REG_ROTATION_MODE, 0, 0, 128, 128, 1, 0, 1, 1, 0, 0, 0, 1},
    '{STEP_PIXEL, REG_ROTATION_MODE, 0, 255, 255, 255, 640, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_PIXEL, REG_ROTATION_MODE, 0, 128, 0, 0, 0, 480, 0, 0, 0, 0, 0, 0},
    '{STEP_PIXEL, REG_ROTATION_MODE, 0, 200, 0, 255, 4095, 4095, 0, 0, 0, 0, 0, 0},
    '{STEP_PIXEL, REG_ROTATION_MODE, 0, 81, 90, 200, 100, 200, 0, 0, 0, 0, 0, 0},
    '{STEP_WRITE, REG_SPARE_6, 8191, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_WRITE, REG_SPARE_7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_PIXEL, REG_ROTATION_MODE, 0, 16, 128, 128, 5, 2, 1, 1285, 0, 0, 0, 1},
    // upper data bits set: only the low two bits reach the mode
    '{STEP_WRITE, REG_ROTATION_MODE, {11'h7ff, ROT_90}, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_PIXEL, REG_ROTATION_MODE, 0, 235, 240, 16, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_PIXEL, REG_ROTATION_MODE, 0, 16, 16, 240, 479, 479, 0, 0, 0, 0, 0, 0},
    '{STEP_WRITE, REG_ROTATION_MODE, {11'd0, ROT_180}, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_PIXEL, REG_ROTATION_MODE, 0, 235, 128, 128, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_PIXEL, REG_ROTATION_MODE, 0, 50, 60, 70, 639, 479, 0, 0, 0, 0, 0, 0},
    '{STEP_WRITE, REG_ROTATION_MODE, {11'd0, ROT_270}, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_PIXEL, REG_ROTATION_MODE, 0, 100, 200, 50, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_PIXEL, REG_ROTATION_MODE, 0, 255, 0, 255, 479, 479, 0, 0, 0, 0, 0, 0},
    // zero width: nothing is drawn
    '{STEP_WRITE, REG_DEST_WIDTH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_PIXEL, REG_ROTATION_MODE, 0, 16, 128, 128, 0, 0, 1, 0, 0, 0, 0, 0},
    // oversized dimensions saturate at the maximum
    '{STEP_WRITE, REG_DEST_WIDTH, 8191, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_WRITE, REG_DEST_HEIGHT, 8191, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_WRITE, REG_DEST_STRIDE, 8191, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_WRITE, REG_CROP_WIDTH, 8191, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_WRITE, REG_CROP_HEIGHT, 8191, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_PIXEL, REG_ROTATION_MODE, 0, 16, 128, 128, 4095, 4095, 0, 0, 0, 0, 0, 0},
    '{STEP_PIXEL, REG_ROTATION_MODE, 0, 255, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_WRITE, REG_ROTATION_MODE, {11'd0, ROT_NONE}, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_PIXEL, REG_ROTATION_MODE, 0, 16, 128, 128, 4095, 4095, 1, 16777215, 0, 0, 0, 1},
    // zero stride collapses the row term
    '{STEP_WRITE, REG_DEST_STRIDE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_PIXEL, REG_ROTATION_MODE, 0, 90, 100, 110, 100, 7, 0, 0, 0, 0, 0, 0}
  };

  yuv_to_rgb_rotate_writer i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .luma       (luma),
    .chroma_u   (chroma_u),
    .chroma_v   (chroma_v),
    .src_col    (src_col),
    .src_row    (src_row),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .done       (done),
    .dest_index (dest_index),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .in_range   (in_range)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned sat_dim(input logic [CFG_W-1:0] v);
    if (int'(v) > MAX_DIM_DEFAULT) return MAX_DIM_DEFAULT;
    return 32'(v);
  endfunction

  function automatic logic [SAMPLE_W-1:0] chan8(input int s);
    if (s < 0) return '0;
    if (s > 262143) return '1;
    return SAMPLE_W'(s >> 10);
  endfunction

  // Drawn width and height; the 90 and 270 placements clip against swapped axes.
  function automatic void drawn_area(output int unsigned w, output int unsigned h);
    int unsigned dw, dh, cw, ch;
    dw = sat_dim(cur_dest_w);
    dh = sat_dim(cur_dest_h);
    cw = sat_dim(cur_crop_w);
    ch = sat_dim(cur_crop_h);
    if (cur_mode == ROT_90 || cur_mode == ROT_270) begin
      w = (dh < cw) ? dh : cw;
      h = (dw < ch) ? dw : ch;
    end else begin
      w = (dw < cw) ? dw : cw;
      h = (dh < ch) ? dh : ch;
    end
  endfunction

  function automatic placed_t convert_and_place(input pixel_t px);
    placed_t         res;
    int              yl, uc, vc;
    int unsigned     w, h, dw, dh, ds;
    longint unsigned pos;
    yl = int'(px.luma) - 16;
    if (yl < 0) yl = 0;
    uc = int'(px.cu) - 128;
    vc = int'(px.cv) - 128;
    drawn_area(w, h);
    dw = sat_dim(cur_dest_w);
    dh = sat_dim(cur_dest_h);
    ds = sat_dim(cur_stride);
    res.ok = (px.col < w) && (px.row < h);
    pos = 0;
    if (res.ok) begin
      case (cur_mode)
        ROT_NONE: pos = 64'(px.row) * 64'(ds) + 64'(px.col);
        ROT_90: begin
          // centred in the destination
          pos = (64'(px.col) + 64'((dh - w) / 2)) * 64'(ds) + 64'((dw - h) / 2)
                + 64'(h - 1 - px.row);
        end
        ROT_180: pos = 64'(h - 1 - px.row) * 64'(ds) + 64'(w - 1 - px.col);
        default: pos = 64'(w - 1 - px.col) * 64'(ds) + 64'(px.row);
      endcase
    end
    res.idx   = pos[DEST_INDEX_W-1:0];
    res.red   = chan8(1192 * yl + 1634 * vc);
    res.green = chan8(1192 * yl - 833 * vc - 400 * uc);
    res.blue  = chan8(1192 * yl + 2066 * uc);
    return res;
  endfunction

  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CFG_W-1:0] rand_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return CFG_W'(1);
    if (r < 15) return CFG_W'(MAX_DIM_DEFAULT);
    if (r < 20) return CFG_W'($urandom_range(MAX_DIM_DEFAULT + 1, 8191));
    if (r < 60) return CFG_W'($urandom_range(1, 64));
    return CFG_W'($urandom_range(1, MAX_DIM_DEFAULT));
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    if ($urandom_range(0, 9) != 0) return SAMPLE_W'($urandom);
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd16;
      2: return 8'd128;
      default: return 8'd255;
    endcase
  endfunction

  // Mostly inside the drawn area, some on its corners or just past its right or bottom edge, the rest anywhere.
  function automatic pixel_t rand_pixel(input int unsigned w, input int unsigned h);
    pixel_t px;
    int     r;
    px.luma = rand_sample();
    px.cu   = rand_sample();
    px.cv   = rand_sample();
    r = $urandom_range(0, 99);
    if (w == 0 || h == 0 || r >= 85) begin
      px.col = POS_W'($urandom);
      px.row = POS_W'($urandom);
    end else if (r < 15) begin
      px.col = $urandom_range(0, 1) ? POS_W'(w - 1) : '0;
      px.row = $urandom_range(0, 1) ? POS_W'(h - 1) : '0;
    end else if (r < 75) begin
      px.col = POS_W'($urandom_range(0, w - 1));
      px.row = POS_W'($urandom_range(0, h - 1));
    end else if (r < 80) begin
      px.col = POS_W'(w);
      px.row = POS_W'($urandom_range(0, h - 1));
    end else begin
      px.col = POS_W'($urandom_range(0, w - 1));
      px.row = POS_W'(h);
    end
    return px;
  endfunction

  // Leaves start high after the transfer so that a following pixel can go back to back.
  task automatic send_pixel(input pixel_t px, input placed_t want, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start    <= 1'b1;
    luma     <= px.luma;
    chroma_u <= px.cu;
    chroma_v <= px.cv;
    src_col  <= px.col;
    src_row  <= px.row;
    do @(posedge clk); while (busy);
    pending_pixels.push_back(want);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_ROTATION_MODE: cur_mode   = rot_mode_t'(val[1:0]);
      REG_DEST_WIDTH:    cur_dest_w = val;
      REG_DEST_HEIGHT:   cur_dest_h = val;
      REG_DEST_STRIDE:   cur_stride = val;
      REG_CROP_WIDTH:    cur_crop_w = val;
      REG_CROP_HEIGHT:   cur_crop_h = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      failed = 1'b1;
      if (msg_count < MAX_MSGS)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      msg_count++;
    end
  endtask

  always @(posedge clk) begin : watch_results
    placed_t want;
    if (!rst && done) begin
      if (pending_pixels.size() == 0) begin
        failed = 1'b1;
        if (msg_count < MAX_MSGS)
          $display("%0t: result with none expected: expected nothing, got index %0d",
                   $time, dest_index);
        msg_count++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("dest_index", 32'(want.idx), 32'(dest_index));
        check_field("red", 32'(want.red), 32'(red));
        check_field("green", 32'(want.green), 32'(green));
        check_field("blue", 32'(want.blue), 32'(blue));
        check_field("in_range", 32'(want.ok), 32'(in_range));
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    pixel_t      px;
    placed_t     want;
    int unsigned w, h;
    bit          quiet;
    int          n;
    failed     = 1'b0;
    msg_count  = 0;
    rst        = 1'b1;
    start      = 1'b0;
    luma       = '0;
    chroma_u   = '0;
    chroma_v   = '0;
    src_col    = '0;
    src_row    = '0;
    cfg_write  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    cur_mode   = ROT_NONE;
    cur_dest_w = DEST_WIDTH_RST;
    cur_dest_h = DEST_HEIGHT_RST;
    cur_stride = DEST_STRIDE_RST;
    cur_crop_w = CROP_WIDTH_RST;
    cur_crop_h = CROP_HEIGHT_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_steps[i]) begin
      if (dir_steps[i].kind == STEP_WRITE) begin
        hold_until_drained();
        write_reg(dir_steps[i].reg_idx, dir_steps[i].reg_val);
      end else begin
        px = '{dir_steps[i].luma, dir_steps[i].cu, dir_steps[i].cv,
               dir_steps[i].col, dir_steps[i].row};
        if (dir_steps[i].typed)
          want = '{dir_steps[i].w_idx, dir_steps[i].w_red, dir_steps[i].w_green,
                   dir_steps[i].w_blue, dir_steps[i].w_ok};
        else
          want = convert_and_place(px);
        send_pixel(px, want, pick_gap(1'b0));
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      hold_until_drained();
      // every placement in turn, with junk in the upper data bits
      write_reg(REG_ROTATION_MODE, {11'($urandom), 2'(ph % 4)});
      write_reg(REG_DEST_WIDTH, rand_dim());
      write_reg(REG_DEST_HEIGHT, rand_dim());
      write_reg(REG_DEST_STRIDE, rand_dim());
      write_reg(REG_CROP_WIDTH, rand_dim());
      write_reg(REG_CROP_HEIGHT, rand_dim());
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, CFG_W'($urandom));
      drawn_area(w, h);
      quiet = ($urandom_range(0, 3) == 0);
      n = $urandom_range(18, 34);
      repeat (n) begin
        if ($urandom_range(0, 39) == 0) hold_until_drained();
        px = rand_pixel(w, h);
        send_pixel(px, convert_and_place(px), pick_gap(quiet));
      end
    end

    hold_until_drained();
    repeat (PIPE_LAT + 4) @(posedge clk);
    if (!failed && pending_pixels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
